// ===== hw/rtl/srs_pkg.sv =====
// Package for the stepper ramp sequencer: coil codes, phase tables,
// configuration register indices and command codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srs_pkg;

  localparam int unsigned PeriodW = 8;
  localparam int unsigned StepsW  = 15;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned CoilW   = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MoveW   = 16;

  localparam logic [CoilW-1:0] NORTH = 4'b0001;
  localparam logic [CoilW-1:0] EAST  = 4'b0010;
  localparam logic [CoilW-1:0] SOUTH = 4'b0100;
  localparam logic [CoilW-1:0] WEST  = 4'b1000;

  localparam logic [CfgIdxW-1:0] CFG_FAST_PERIOD    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SLOW_PERIOD    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FULL_STEP_MODE = 2'd2;

  localparam logic [PeriodW-1:0] FAST_PERIOD_RST = 8'd11;
  localparam logic [PeriodW-1:0] SLOW_PERIOD_RST = 8'd32;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

  // Eight-phase half-step pattern
  function automatic logic [CoilW-1:0] half_coil(input logic [PhaseW-1:0] ph);
    logic [CoilW-1:0] c;
    case (ph)
      3'd0:    c = NORTH;
      3'd1:    c = NORTH | EAST;
      3'd2:    c = EAST;
      3'd3:    c = SOUTH | EAST;
      3'd4:    c = SOUTH;
      3'd5:    c = SOUTH | WEST;
      3'd6:    c = WEST;
      3'd7:    c = NORTH | WEST;
      default: c = NORTH;
    endcase
    return c;
  endfunction

  // Four-phase full-step pattern, two coils on at a time
  function automatic logic [CoilW-1:0] full_coil(input logic [1:0] ph);
    logic [CoilW-1:0] c;
    case (ph)
      2'd0:    c = NORTH | EAST;
      2'd1:    c = SOUTH | EAST;
      2'd2:    c = SOUTH | WEST;
      2'd3:    c = NORTH | WEST;
      default: c = NORTH | EAST;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/srs_in_if.sv =====
// Input channel of the stepper ramp sequencer: valid/ready plus one item.
// Depends on srs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface srs_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  func;
  logic signed [srs_pkg::MoveW-1:0]      move_steps;

  modport source(output valid, output func, output move_steps, input ready);
  modport sink(input valid, input func, input move_steps, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/srs_out_if.sv =====
// Result channel of the stepper ramp sequencer: valid/ready plus one result.
// Depends on srs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface srs_out_if;
  logic                        valid;
  logic                        ready;
  logic [srs_pkg::CoilW-1:0]   coil_lines;
  logic                        running;
  logic                        step_pulse;

  modport source(output valid, output coil_lines, output running, output step_pulse,
                 input ready);
  modport sink(input valid, input coil_lines, input running, input step_pulse,
               output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stepper_ramp_sequencer_core.sv =====
// Stepper ramp sequencer top level: motion state, ramp logic and result register.
// Depends on srs_pkg, srs_in_if and srs_out_if.
//
// Unipolar stepper sequencer with a trapezoidal speed ramp. Each input beat is either
// one prescaled timer tick or a signed move command; each produces exactly one result
// beat carrying the coil drive lines, the running flag and a step pulse. A beat is
// handled at acceptance: the motion state updates and the result lands in the output
// register, visible in the next cycle. One beat per clock is sustained while results
// are taken; the output register decouples the sides, so a new beat is taken whenever
// the register is empty or its beat is taken in the same cycle. Configuration (fast
// period, slow period, full/half step) must be written only while idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none

module stepper_ramp_sequencer_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [srs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [srs_pkg::PeriodW-1:0]   cfg_wdata_i,
  srs_in_if.sink                             in_i,
  srs_out_if.source                          out_o
);

  localparam int unsigned PW = srs_pkg::PeriodW;
  localparam int unsigned SW = srs_pkg::StepsW;
  localparam int unsigned HW = srs_pkg::PhaseW;
  localparam int unsigned CW = srs_pkg::CoilW;
  localparam int unsigned MW = srs_pkg::MoveW;

  // configuration
  logic [PW-1:0] fast_q, slow_q;
  logic          full_q;

  // motion state
  logic          active_q, active_d;
  logic          fwd_q, fwd_d;
  logic [SW-1:0] rem_q, rem_d;
  logic [PW-1:0] period_q, period_d;
  logic [PW-1:0] cnt_q, cnt_d;
  logic [HW-1:0] phase_q, phase_d;
  logic [CW-1:0] coil_q, coil_d;
  logic          pend_q, pend_d;
  logic          pend_fwd_q, pend_fwd_d;
  logic [SW-1:0] pend_steps_q, pend_steps_d;
  logic          pulse_d;

  // result register
  logic          out_valid_q;
  logic [CW-1:0] out_coil_q;
  logic          out_run_q;
  logic          out_pulse_q;

  logic          in_ready;
  logic          accept;

  logic [MW-1:0]        raw;
  logic [MW-1:0]        mag_full;
  logic [SW-1:0]        mag;
  logic                 cmd_fwd;
  logic [PW-1:0]        stop_dist;
  logic [SW-1:0]        stop_dist_w;
  logic [PW-1:0]        cnt_dec;
  logic [SW-1:0]        rem_dec;
  logic [HW-1:0]        phase_step;
  logic signed [SW+1:0] target;

  assign in_ready   = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // command magnitude; the most negative code saturates
  assign raw      = in_i.move_steps;
  assign cmd_fwd  = !raw[MW-1];
  assign mag_full = cmd_fwd ? raw : (MW'(0) - raw);
  assign mag      = mag_full[MW-1] ? {SW{1'b1}} : mag_full[SW-1:0];

  assign stop_dist   = (slow_q > fast_q) ? (slow_q - fast_q) : '0;
  assign stop_dist_w = SW'(stop_dist);

  assign cnt_dec    = cnt_q - PW'(1);
  assign rem_dec    = rem_q - SW'(1);
  assign phase_step = fwd_q ? (phase_q + HW'(1)) : (phase_q - HW'(1));
  assign target     = $signed({2'b00, SW'(slow_q)}) - $signed({2'b00, rem_dec});

  always_comb begin
    active_d     = active_q;
    fwd_d        = fwd_q;
    rem_d        = rem_q;
    period_d     = period_q;
    cnt_d        = cnt_q;
    phase_d      = phase_q;
    coil_d       = coil_q;
    pend_d       = pend_q;
    pend_fwd_d   = pend_fwd_q;
    pend_steps_d = pend_steps_q;
    pulse_d      = 1'b0;

    if (in_i.func == srs_pkg::FUNC_TICK) begin
      if (active_q) begin
        cnt_d = cnt_dec;
        if (cnt_dec == '0) begin
          if (rem_q == '0) begin
            // stop event; a pending reversal starts straight away
            active_d = 1'b0;
            coil_d   = '0;
            if (pend_q) begin
              pend_d   = 1'b0;
              fwd_d    = pend_fwd_q;
              rem_d    = pend_steps_q;
              period_d = slow_q;
              cnt_d    = PW'(1);
              active_d = 1'b1;
            end
          end else begin
            pulse_d = 1'b1;
            rem_d   = rem_dec;
            phase_d = phase_step;
            coil_d  = full_q ? srs_pkg::full_coil(phase_step[1:0])
                             : srs_pkg::half_coil(phase_step);
            if ($signed({2'b00, SW'(period_q)}) < target) begin
              // decelerate: period follows slow minus remaining
              period_d = target[PW-1:0];
              cnt_d    = target[PW-1:0];
            end else begin
              cnt_d = period_q;
              if (period_q > fast_q) begin
                period_d = period_q - PW'(1);
              end
            end
          end
        end
      end
    end else begin
      if (active_q) begin
        if (mag == '0 || cmd_fwd == fwd_q) begin
          if (mag > stop_dist_w) begin
            rem_d = mag;
          end else if (rem_q > stop_dist_w) begin
            rem_d = stop_dist_w;
          end
          pend_d = 1'b0;
        end else begin
          if (rem_q > stop_dist_w) begin
            rem_d = stop_dist_w;
          end
          pend_d       = 1'b1;
          pend_fwd_d   = cmd_fwd;
          pend_steps_d = mag;
        end
      end else if (mag != '0) begin
        fwd_d    = cmd_fwd;
        rem_d    = mag;
        period_d = slow_q;
        cnt_d    = PW'(1);
        active_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= srs_pkg::FAST_PERIOD_RST;
      slow_q <= srs_pkg::SLOW_PERIOD_RST;
      full_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srs_pkg::CFG_FAST_PERIOD:    fast_q <= cfg_wdata_i;
        srs_pkg::CFG_SLOW_PERIOD:    slow_q <= cfg_wdata_i;
        srs_pkg::CFG_FULL_STEP_MODE: full_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      fwd_q        <= 1'b0;
      rem_q        <= '0;
      period_q     <= '0;
      cnt_q        <= '0;
      phase_q      <= '0;
      coil_q       <= '0;
      pend_q       <= 1'b0;
      pend_fwd_q   <= 1'b0;
      pend_steps_q <= '0;
    end else if (accept) begin
      active_q     <= active_d;
      fwd_q        <= fwd_d;
      rem_q        <= rem_d;
      period_q     <= period_d;
      cnt_q        <= cnt_d;
      phase_q      <= phase_d;
      coil_q       <= coil_d;
      pend_q       <= pend_d;
      pend_fwd_q   <= pend_fwd_d;
      pend_steps_q <= pend_steps_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_coil_q  <= coil_d;
      out_run_q   <= active_d || pend_d;
      out_pulse_q <= pulse_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.coil_lines = out_coil_q;
  assign out_o.running    = out_run_q;
  assign out_o.step_pulse = out_pulse_q;

endmodule

`default_nettype wire

// ===== hw/rtl/srs_checker.sv =====
// Port-level checks for stepper_ramp_sequencer_core, bound to the top level.
// Depends on srs_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module srs_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [srs_pkg::CoilW-1:0]   coil_lines,
  input wire logic                        running,
  input wire logic                        step_pulse
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(coil_lines) && $stable(running)
      && $stable(step_pulse))
    else $error("result beat changed while stalled");

  // every accepted beat shows a result on the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

  // a step only happens while the motor keeps running with energised coils
  a_step_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && step_pulse |-> running && (coil_lines != '0))
    else $error("step pulse without running or energised coils");

  // stopped motor has every coil off
  a_stop_coils: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !running |-> coil_lines == '0)
    else $error("coils energised while stopped");

endmodule

bind stepper_ramp_sequencer_core srs_checker u_srs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .coil_lines (out_o.coil_lines),
  .running    (out_o.running),
  .step_pulse (out_o.step_pulse)
);

`default_nettype wire
